### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(name, ante, cons)

`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

### hw/rtl/prru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prru_pkg
// Widths, reset values, opcodes and shared types of the PageRank row update.
// ----------------------------------------------------------------------------
package prru_pkg;

    localparam int MAX_NODES_DEF = 8192;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 13;
    localparam int RANK_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int DAMP_W   = 17;
    localparam int RECIP_W  = 32;
    localparam int COUNT_W  = 14;
    localparam int TOL_W    = 16;
    localparam int SUM_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;
    localparam int CMP_W    = 17;

    localparam logic [DAMP_W-1:0]  DAMP_ONE      = 17'd65536;
    localparam logic [DAMP_W-1:0]  DAMP_RESET    = 17'd55705;
    localparam logic [RECIP_W-1:0] RECIP_RESET   = 32'd603640;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 14'd7115;
    localparam logic [TOL_W-1:0]   TOL_RESET     = 16'd0;
    localparam logic [SUM_W-1:0]   SUM_MAX       = {SUM_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_START     = 3'd0,
        OP_LOAD      = 3'd1,
        OP_DANGLING  = 3'd2,
        OP_EDGE      = 3'd3,
        OP_EMPTY_ROW = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DAMPING   = 2'd0,
        REG_RECIP     = 2'd1,
        REG_NODE_CNT  = 2'd2,
        REG_TOLERANCE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              done;
        logic [RANK_W-1:0] new_rank;
    } calc_res_t;

endpackage

### hw/rtl/prru_rank_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prru_rank_calc
// Four-stage datapath: damping*(row sum + dangling sum/N) + (1 - damping).
// ----------------------------------------------------------------------------
module prru_rank_calc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [prru_pkg::SUM_W-1:0]     dangling_sum,
    input  logic [prru_pkg::SUM_W-1:0]     row_sum,
    input  logic [prru_pkg::RECIP_W-1:0]   recip_nodes,
    input  logic [prru_pkg::DAMP_W-1:0]    damping,
    output prru_pkg::calc_res_t            res
);
    import prru_pkg::*;

    localparam int TOT_W = SUM_W + 2;
    localparam int P1_W  = DAMP_W + TOT_W - 16;
    localparam int P2_W  = DAMP_W + 16;
    localparam int R_W   = P1_W + 2;

    logic                   v1_reg, v2_reg, v3_reg, done_reg;
    logic [DAMP_W-1:0]      d_reg;
    logic [SUM_W-1:0]       rsum_reg;
    logic [SUM_W-1:0]       mul_hi_reg;
    logic [63:0]            mul_lo_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [P1_W-1:0]        p1_reg;
    logic [P2_W-1:0]        p2_reg;
    logic [RANK_W-1:0]      new_rank_reg;
    logic [R_W-1:0]         r_next;
    logic [DAMP_W-1:0]      d_clip;

    assign d_clip = (damping > DAMP_ONE) ? DAMP_ONE : damping;
    assign r_next = R_W'(p1_reg) + R_W'(p2_reg[P2_W-1:16]) + R_W'(DAMP_ONE - d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg      <= d_clip;
            rsum_reg   <= row_sum;
            mul_hi_reg <= SUM_W'(dangling_sum[SUM_W-1:32]) * SUM_W'(recip_nodes);
            mul_lo_reg <= 64'(dangling_sum[31:0]) * 64'(recip_nodes);
        end
        if (v1_reg)
        begin
            total_reg <= TOT_W'(rsum_reg) + TOT_W'(mul_hi_reg) + TOT_W'(mul_lo_reg[63:32]);
        end
        if (v2_reg)
        begin
            p1_reg <= P1_W'(d_reg) * P1_W'(total_reg[TOT_W-1:16]);
            p2_reg <= P2_W'(d_reg) * P2_W'(total_reg[15:0]);
        end
        if (v3_reg)
        begin
            new_rank_reg <= (r_next > R_W'({RANK_W{1'b1}})) ? {RANK_W{1'b1}}
                                                             : r_next[RANK_W-1:0];
        end
    end

    assign res.done     = done_reg;
    assign res.new_rank = new_rank_reg;

endmodule

### hw/rtl/pagerank_row_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_row_update_core
// One PageRank pass over a CSR stream, Q16.16, old ranks held in one RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Contents
// s_axis    in         tvalid/tready            opcode, node, rank, weight, row end
// m_axis    out        tvalid/tready            new rank, row, last row, converged
// cfg       in         cfg_wr_en, no wait       damping, 1/N, node count, tolerance
//
// Dangling items and edges read the RAM and add to the dangling or row sum.
// A finished row (edge with row end, or empty row) reads its old rank and runs
// the four-stage rank datapath. One item is in work at a time; a finished row
// waits in the output register and stalls only the next finished row. Reset
// needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pagerank_row_update_core #(
    parameter int MAX_NODES = prru_pkg::MAX_NODES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // node_index[12:0], rank_value[44:13], edge_weight[61:45], zero[63:62]
    input  logic [prru_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode[2:0]
    input  logic [prru_pkg::OP_W-1:0]         s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // new_rank[31:0], row_index[44:32], all_converged[45], zero[47:46]
    output logic [prru_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              cfg_wr_en,
    input  logic [prru_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [prru_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import prru_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC,
        S_EDGE,
        S_FIN,
        S_FIN_OLD,
        S_FIN_WAIT,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    op_t                    in_op, op_reg;
    logic [DAMP_W-1:0]      damping_reg;
    logic [RECIP_W-1:0]     recip_reg;
    logic [COUNT_W-1:0]     node_count_reg;
    logic [TOL_W-1:0]       tol_reg;
    logic [SUM_W-1:0]       dsum_reg, row_sum_reg;
    logic [COUNT_W-1:0]     row_counter_reg;
    logic                   conv_reg;
    logic [WEIGHT_W-1:0]    w_reg;
    logic                   end_reg;
    logic [WEIGHT_W+RANK_W-1:0] prod_reg;
    logic [RANK_W-1:0]      old_reg, nr_reg;
    logic                   out_valid_reg, out_last_reg, out_conv_reg;
    logic [RANK_W-1:0]      out_rank_reg;
    logic [IDX_W-1:0]       out_row_reg;

    logic [RANK_W-1:0]      rank_mem [MAX_NODES];
    logic [RANK_W-1:0]      rd_data_reg;
    logic                   rd_ok_reg;

    logic                   accept;
    logic [IDX_W-1:0]       in_idx;
    logic [RANK_W-1:0]      in_rank;
    logic [WEIGHT_W-1:0]    in_weight;
    logic [CMP_W-1:0]       idx_ext, cnt_ext;
    logic                   idx_ok, cnt_ok;
    logic                   mem_we, mem_re, rd_ok_next;
    logic [AW-1:0]          rd_addr;
    logic [RANK_W-1:0]      rank_rd, diff;
    logic [SUM_W:0]         dsum_add, rsum_add;
    logic [SUM_W-1:0]       dsum_next, row_sum_next;
    logic                   last_next, conv_next, emit;
    calc_res_t              calc_res;

    assign in_op     = op_t'(s_axis_tuser);
    assign in_idx    = s_axis_tdata[IDX_W-1:0];
    assign in_rank   = s_axis_tdata[IDX_W+RANK_W-1:IDX_W];
    assign in_weight = s_axis_tdata[IDX_W+RANK_W+WEIGHT_W-1:IDX_W+RANK_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign idx_ext = CMP_W'(in_idx);
    assign cnt_ext = CMP_W'(row_counter_reg);
    assign idx_ok  = idx_ext < CMP_W'(MAX_NODES);
    assign cnt_ok  = cnt_ext < CMP_W'(MAX_NODES);

    assign mem_we = accept && (in_op == OP_LOAD) && idx_ok;
    assign mem_re = (accept && (in_op == OP_DANGLING || in_op == OP_EDGE))
                    || (state_reg == S_FIN);
    assign rd_addr    = (state_reg == S_FIN) ? cnt_ext[AW-1:0] : idx_ext[AW-1:0];
    assign rd_ok_next = (state_reg == S_FIN) ? cnt_ok : idx_ok;
    assign rank_rd    = rd_ok_reg ? rd_data_reg : '0;

    assign dsum_add     = (SUM_W+1)'(dsum_reg) + (SUM_W+1)'(rank_rd);
    assign dsum_next    = dsum_add[SUM_W] ? SUM_MAX : dsum_add[SUM_W-1:0];
    assign rsum_add     = (SUM_W+1)'(row_sum_reg) + (SUM_W+1)'(prod_reg[WEIGHT_W+RANK_W-1:16]);
    assign row_sum_next = rsum_add[SUM_W] ? SUM_MAX : rsum_add[SUM_W-1:0];

    assign diff      = (nr_reg > old_reg) ? (nr_reg - old_reg) : (old_reg - nr_reg);
    assign conv_next = conv_reg && !(diff > RANK_W'(tol_reg));
    assign last_next = (COUNT_W'(row_counter_reg + 1'b1) == node_count_reg);
    assign emit      = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    prru_rank_calc u_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (state_reg == S_FIN),
        .dangling_sum (dsum_reg),
        .row_sum      (row_sum_reg),
        .recip_nodes  (recip_reg),
        .damping      (damping_reg),
        .res          (calc_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rank_mem[idx_ext[AW-1:0]] <= in_rank;
        end
        if (mem_re)
        begin
            rd_data_reg <= rank_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            damping_reg     <= DAMP_RESET;
            recip_reg       <= RECIP_RESET;
            node_count_reg  <= COUNT_RESET;
            tol_reg         <= TOL_RESET;
            dsum_reg        <= '0;
            row_sum_reg     <= '0;
            row_counter_reg <= '0;
            conv_reg        <= 1'b1;
            op_reg          <= OP_START;
            w_reg           <= '0;
            end_reg         <= 1'b0;
            prod_reg        <= '0;
            old_reg         <= '0;
            nr_reg          <= '0;
            rd_ok_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_rank_reg    <= '0;
            out_row_reg     <= '0;
            out_last_reg    <= 1'b0;
            out_conv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_DAMPING:   damping_reg    <= cfg_wdata[DAMP_W-1:0];
                    REG_RECIP:     recip_reg      <= cfg_wdata[RECIP_W-1:0];
                    REG_NODE_CNT:  node_count_reg <= cfg_wdata[COUNT_W-1:0];
                    REG_TOLERANCE: tol_reg        <= cfg_wdata[TOL_W-1:0];
                    default:       ;
                endcase
            end

            if (mem_re)
            begin
                rd_ok_reg <= rd_ok_next;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg  <= in_op;
                        w_reg   <= in_weight;
                        end_reg <= s_axis_tlast;
                        case (in_op)
                            OP_START:
                            begin
                                dsum_reg        <= '0;
                                row_sum_reg     <= '0;
                                row_counter_reg <= '0;
                                conv_reg        <= 1'b1;
                            end
                            OP_DANGLING, OP_EDGE: state_reg <= S_SRC;
                            OP_EMPTY_ROW:         state_reg <= S_FIN;
                            default:              ;
                        endcase
                    end
                end
                S_SRC:
                begin
                    if (op_reg == OP_DANGLING)
                    begin
                        dsum_reg  <= dsum_next;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prod_reg  <= (WEIGHT_W+RANK_W)'(w_reg) * (WEIGHT_W+RANK_W)'(rank_rd);
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    row_sum_reg <= row_sum_next;
                    state_reg   <= end_reg ? S_FIN : S_IDLE;
                end
                S_FIN:
                begin
                    state_reg <= S_FIN_OLD;
                end
                S_FIN_OLD:
                begin
                    old_reg   <= rank_rd;
                    state_reg <= S_FIN_WAIT;
                end
                S_FIN_WAIT:
                begin
                    if (calc_res.done)
                    begin
                        nr_reg    <= calc_res.new_rank;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit)
                    begin
                        out_rank_reg    <= nr_reg;
                        out_row_reg     <= row_counter_reg[IDX_W-1:0];
                        out_last_reg    <= last_next;
                        out_conv_reg    <= conv_next;
                        conv_reg        <= conv_next;
                        row_sum_reg     <= '0;
                        row_counter_reg <= COUNT_W'(row_counter_reg + 1'b1);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_conv_reg, out_row_reg, out_rank_reg};
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_IMPL(a_calc_done_wait, calc_res.done, state_reg == S_FIN_WAIT)
    `ASSERT_NEXT(a_conv_sticky, !conv_reg && !(accept && in_op == OP_START), !conv_reg)
    `ASSERT_NEXT(a_count_hold, !emit && !(accept && in_op == OP_START), $stable(row_counter_reg))

endmodule

### bench/pagerank_row_update_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_row_update_core_tb
// Self-checking bench for the PageRank row update core. A rank-pass model
// predicts every finished row from the accepted items and checks each
// output item against the oldest prediction. The stream is built from short
// passes (start, loads, dangling nodes, rows of edges) with random content,
// some noise, random gaps and stalls on both sides, and several register
// settings.
// ----------------------------------------------------------------------------
module pagerank_row_update_core_tb;
    import prru_pkg::*;

    typedef struct {
        bit [RANK_W-1:0]  rank;
        bit [IDX_W-1:0]   row;
        bit               last;
        bit               conv;
    } row_result_t;

    class rank_pass_model;
        bit [DAMP_W-1:0]  damping;
        bit [RECIP_W-1:0] recip;
        bit [COUNT_W-1:0] node_cnt;
        bit [TOL_W-1:0]   tol;
        bit [RANK_W-1:0]  old_rank [MAX_NODES_DEF];
        bit               written [MAX_NODES_DEF];
        bit [SUM_W-1:0]   dangle_sum;
        bit [SUM_W-1:0]   row_sum;
        bit [COUNT_W-1:0] row_cnt;
        bit               conv;
        row_result_t      pending_rows [$];
        int               errors;
        int               rows_checked;

        function new();
            damping = DAMP_RESET;
            recip = RECIP_RESET;
            node_cnt = COUNT_RESET;
            tol = TOL_RESET;
            dangle_sum = '0;
            row_sum = '0;
            row_cnt = '0;
            conv = 1'b1;
            errors = 0;
            rows_checked = 0;
        endfunction

        function void write_reg(cfg_reg_t r, bit [CFG_DATA_W-1:0] v);
            case (r)
                REG_DAMPING:   damping = v[DAMP_W-1:0];
                REG_RECIP:     recip = v[RECIP_W-1:0];
                REG_NODE_CNT:  node_cnt = v[COUNT_W-1:0];
                REG_TOLERANCE: tol = v[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [RANK_W-1:0] read_rank(bit [COUNT_W-1:0] a);
            return (a < MAX_NODES_DEF) ? old_rank[a] : '0;
        endfunction

        function bit [SUM_W-1:0] sat_add(bit [SUM_W-1:0] a, bit [SUM_W-1:0] b);
            bit [SUM_W:0] s;
            s = a + b;
            return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        // rank the current row would get if it finished now
        function bit [RANK_W-1:0] next_rank();
            bit [DAMP_W-1:0] d;
            bit [79:0]       share;
            bit [49:0]       total;
            bit [66:0]       damped;
            bit [67:0]       r;
            d = (damping > DAMP_ONE) ? DAMP_ONE : damping;
            share = dangle_sum;
            share = (share * recip) >> 32;
            total = row_sum + share[49:0];
            damped = d;
            damped = (damped * total) >> 16;
            r = damped + (DAMP_ONE - d);
            return (r > 68'hFFFF_FFFF) ? '1 : r[RANK_W-1:0];
        endfunction

        function void finish_row();
            row_result_t      e;
            bit [RANK_W-1:0]  old;
            bit [RANK_W-1:0]  diff;
            bit [COUNT_W-1:0] nxt;
            e.rank = next_rank();
            old = read_rank(row_cnt);
            diff = (e.rank > old) ? e.rank - old : old - e.rank;
            if (diff > tol)
                conv = 1'b0;
            nxt = row_cnt + 14'd1;
            e.row = row_cnt[IDX_W-1:0];
            e.last = (nxt == node_cnt);
            e.conv = conv;
            pending_rows.push_back(e);
            row_sum = '0;
            row_cnt = nxt;
        endfunction

        function void take_item(bit [OP_W-1:0] op, bit [IDX_W-1:0] idx,
                                bit [RANK_W-1:0] val, bit [WEIGHT_W-1:0] w, bit fin);
            bit [48:0] term;
            case (op)
                OP_START:
                begin
                    dangle_sum = '0;
                    row_sum = '0;
                    row_cnt = '0;
                    conv = 1'b1;
                end
                OP_LOAD:
                begin
                    old_rank[idx] = val;
                    written[idx] = 1'b1;
                end
                OP_DANGLING:
                    dangle_sum = sat_add(dangle_sum, read_rank(idx));
                OP_EDGE:
                begin
                    term = w;
                    term = (term * read_rank(idx)) >> 16;
                    row_sum = sat_add(row_sum, term[SUM_W-1:0]);
                    if (fin)
                        finish_row();
                end
                OP_EMPTY_ROW:
                    finish_row();
                default: ;
            endcase
        endfunction

        function void check_row(logic [OUT_DATA_W-1:0] data, logic last);
            row_result_t e;
            if (pending_rows.size() == 0)
            begin
                $error("row result with none pending: data %h last %b", data, last);
                errors++;
                return;
            end
            e = pending_rows.pop_front();
            rows_checked++;
            if (data[31:0] !== e.rank)
            begin
                $error("new_rank: expected %h, got %h", e.rank, data[31:0]);
                errors++;
            end
            if (data[44:32] !== e.row)
            begin
                $error("row_index: expected %0d, got %0d", e.row, data[44:32]);
                errors++;
            end
            if (data[45] !== e.conv)
            begin
                $error("all_converged: expected %b, got %b", e.conv, data[45]);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_row: expected %b, got %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [OP_W-1:0]         s_axis_tuser = '0;
    logic                    s_axis_tlast = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    rank_pass_model model = new();
    bit [IDX_W-1:0] loaded [$];
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int work_items = 0;
    int settings = 1;

    pagerank_row_update_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            stall_left <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            model.check_row(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_item(bit [OP_W-1:0] op, bit [IDX_W-1:0] idx,
                             bit [RANK_W-1:0] val, bit [WEIGHT_W-1:0] w, bit fin);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, w, val, idx};
        s_axis_tuser <= op;
        s_axis_tlast <= fin;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        if (op == OP_LOAD && !model.written[idx])
            loaded.push_back(idx);
        model.take_item(op, idx, val, w, fin);
        if (op <= OP_EMPTY_ROW)
            work_items++;
    endtask

    // hold the input side idle until every pending row is out, then let the
    // datapath settle
    task automatic drain();
        int spin;
        spin = 0;
        s_axis_tvalid <= 1'b0;
        while (model.pending_rows.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic put_reg(cfg_reg_t r, bit [CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= v;
        @(posedge clk);
        model.write_reg(r, v);
    endtask

    task automatic write_regs(bit [DAMP_W-1:0] d, bit [RECIP_W-1:0] r,
                              bit [COUNT_W-1:0] n, bit [TOL_W-1:0] t);
        put_reg(REG_DAMPING, d);
        put_reg(REG_RECIP, r);
        put_reg(REG_NODE_CNT, n);
        put_reg(REG_TOLERANCE, t);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    function automatic bit [RANK_W-1:0] rand_rank();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    function automatic bit [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return DAMP_ONE;
            1: return '0;
            default: return $urandom_range(1, 65536);
        endcase
    endfunction

    function automatic bit [IDX_W-1:0] pick_node();
        return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(OP_W'($urandom_range(5, 7)), IDX_W'($urandom), $urandom,
                         WEIGHT_W'($urandom), 1'($urandom));
            1: send_item(OP_DANGLING, pick_node(), $urandom, rand_weight(), 1'($urandom));
            default: send_item(OP_LOAD, IDX_W'($urandom), rand_rank(), rand_weight(),
                               1'($urandom));
        endcase
    endtask

    // one pass: optional start, loads, dangling nodes, then rows of edges
    task automatic run_pass();
        int              links;
        int              k;
        int              tol_i;
        int              delta;
        bit              by_link;
        bit [IDX_W-1:0]  a;
        longint          v;
        if (model.row_cnt > 14'd4000 || $urandom_range(0, 3) != 0)
            send_item(OP_START, IDX_W'($urandom), $urandom, rand_weight(), 1'($urandom));
        repeat ($urandom_range(1, 6))
        begin
            a = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 31)) : IDX_W'($urandom);
            send_item(OP_LOAD, a, rand_rank(), rand_weight(), 1'($urandom));
        end
        repeat ($urandom_range(0, 3))
            send_item(OP_DANGLING, pick_node(), $urandom, rand_weight(), 1'($urandom));
        repeat ($urandom_range(1, 8))
        begin
            links = $urandom_range(0, 4);
            by_link = (links > 0) && ($urandom_range(0, 2) != 0);
            a = model.row_cnt[IDX_W-1:0];
            if (!model.written[a])
                send_item(OP_LOAD, a, rand_rank(), rand_weight(), 1'($urandom));
            for (k = 0; k < links; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                send_item(OP_EDGE, pick_node(), $urandom, rand_weight(),
                          by_link && (k == links - 1));
            end
            if (!by_link)
            begin
                // place the old rank near the coming result to exercise the
                // tolerance check on both sides
                if ($urandom_range(0, 1) != 0)
                begin
                    tol_i = model.tol;
                    delta = int'($urandom_range(0, 2 * tol_i + 4)) - (tol_i + 2);
                    v = longint'(model.next_rank()) + delta;
                    if (v < 0)
                        v = 0;
                    if (v > 64'hFFFF_FFFF)
                        v = 64'hFFFF_FFFF;
                    send_item(OP_LOAD, a, RANK_W'(v), rand_weight(), 1'($urandom));
                end
                send_item(OP_EMPTY_ROW, IDX_W'($urandom), $urandom, rand_weight(),
                          1'($urandom));
            end
        end
    endtask

    initial
    begin
        int phase;
        int target;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 30;
        stall_pct = 20;
        send_item(OP_START, '0, '0, '0, 1'b0);
        send_item(OP_LOAD, 13'd0, 32'hFFFF_FFFF, '0, 1'b1);
        send_item(OP_LOAD, 13'd8191, 32'h0000_0000, 17'h1FFFF, 1'b0);
        send_item(OP_LOAD, 13'd1, 32'h0001_0000, '0, 1'b0);
        send_item(OP_LOAD, 13'd2, 32'h0000_D999, '0, 1'b0);
        send_item(OP_DANGLING, 13'd0, '0, '0, 1'b0);
        send_item(OP_DANGLING, 13'd8191, '0, '0, 1'b1);
        send_item(OP_EDGE, 13'd0, '0, DAMP_ONE, 1'b0);
        send_item(OP_EDGE, 13'd1, '0, 17'd0, 1'b0);
        send_item(OP_EDGE, 13'd0, 32'hFFFF_FFFF, DAMP_ONE, 1'b1);
        send_item(3'd5, 13'h1FFF, 32'hFFFF_FFFF, 17'h1FFFF, 1'b1);
        send_item(3'd6, 13'h0AAA, 32'h5555_5555, 17'h0AAAA, 1'b0);
        send_item(3'd7, 13'h1555, 32'hAAAA_AAAA, 17'h15555, 1'b1);
        send_item(OP_EMPTY_ROW, '0, '0, '0, 1'b0);
        send_item(OP_EDGE, 13'd2, '0, 17'd1, 1'b0);
        send_item(OP_EDGE, 13'd8191, '0, 17'd32768, 1'b0);
        send_item(OP_EMPTY_ROW, '0, '0, '0, 1'b1);
        send_item(OP_LOAD, 13'd3, 32'h0000_8000, '0, 1'b0);
        send_item(OP_EDGE, 13'd1, '0, 17'd21845, 1'b1);
        loaded.push_back(13'd4095);
        send_item(OP_LOAD, 13'd4095, 32'h1234_5678, '0, 1'b0);

        for (phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0: write_regs(DAMP_ONE, 32'hFFFF_FFFF, 14'd1, 16'hFFFF);
                1: write_regs('0, '0, '0, '0);
                2: write_regs(17'h1FFFF, $urandom, 14'd3, TOL_W'($urandom));
                3: write_regs(DAMP_W'($urandom_range(0, 65536)), $urandom, 14'd8192, '0);
                default: write_regs(DAMP_W'($urandom_range(0, 65536)), $urandom,
                                    COUNT_W'($urandom_range(1, 12)),
                                    TOL_W'($urandom_range(0, 3000)));
            endcase
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 30;
            endcase
            if (phase == 7)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            target = work_items + 112;
            while (work_items < target)
                run_pass();
        end

        drain();
        if (model.pending_rows.size() != 0)
        begin
            $error("%0d row results never arrived", model.pending_rows.size());
            model.errors++;
        end
        $display("Run covered %0d items and %0d checked row ranks under %0d register settings",
                 work_items, model.rows_checked, settings);
        if (model.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
